// ===== rtl/utf8d_pkg.sv =====
// shared types and constants of the utf-8 stream decoder
`timescale 1ns / 1ps

package utf8d_pkg;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int OUT_DATA_W  = 24;
    localparam int OUT_USER_W  = 2;
    localparam int QUEUE_DEPTH = 4;

    // code point limits
    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO        = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI        = 21'h00DFFF;

    // byte classes
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] PAY2_MASK  = 8'h1F;
    localparam logic [7:0] PAY3_MASK  = 8'h0F;
    localparam logic [7:0] PAY4_MASK  = 8'h07;
    localparam logic [7:0] CONT_PAY   = 8'h3F;

    // sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // work for the back end: some replacements, then an optional tail result
    typedef struct packed {
        logic [1:0]      rep_cnt;
        logic            has_tail;
        logic [CP_W-1:0] tail_cp;
        logic            tail_repl;
        logic            tail_end;
    } t_desc;

    // queue handshake between the front end and the back end
    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

endpackage

// ===== rtl/utf8d_front.sv =====
// front end: accepts bytes, tracks the pending sequence, builds work descriptors
`timescale 1ns / 1ps

module utf8d_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_valid,
    input  logic [utf8d_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                             i_end_of_string,
    input  logic                             i_q_full,
    output logic                             o_s_ready,
    output logic                             o_push,
    output utf8d_pkg::t_desc                 o_desc
);
    import utf8d_pkg::*;

    logic [2:0]      r_exp_len, n_exp_len;
    logic [1:0]      r_seen, n_seen;
    logic [CP_W-1:0] r_part, n_part;

    logic            accept;
    logic            is_end;
    logic            is_cont;
    logic            pending;
    logic [2:0]      seen_inc;
    logic [CP_W-1:0] cont_val;
    logic            bad_val;
    t_desc           desc;

    assign o_s_ready = !i_q_full;
    assign accept    = i_s_valid && o_s_ready;

    // byte classification
    assign is_end   = i_end_of_string || (i_data_byte == '0);
    assign is_cont  = (i_data_byte & CONT_MASK) == CONT_CODE;
    assign pending  = r_exp_len != LEN_NONE;
    assign seen_inc = {1'b0, r_seen} + 3'd1;
    assign cont_val = {r_part[CP_W-7:0], i_data_byte[5:0]};
    assign bad_val  = (cont_val > CP_MAX) || ((cont_val >= SURR_LO) && (cont_val <= SURR_HI));

    // next state and descriptor
    always_comb begin
        n_exp_len      = r_exp_len;
        n_seen         = r_seen;
        n_part         = r_part;
        desc.rep_cnt   = 2'd0;
        desc.has_tail  = 1'b0;
        desc.tail_cp   = '0;
        desc.tail_repl = 1'b0;
        desc.tail_end  = 1'b0;
        if (is_end) begin
            // flush pending bytes, then the end marker
            desc.rep_cnt  = pending ? r_seen : 2'd0;
            desc.has_tail = 1'b1;
            desc.tail_end = 1'b1;
            n_exp_len     = LEN_NONE;
            n_seen        = 2'd0;
            n_part        = '0;
        end else if (pending && is_cont) begin
            if (seen_inc >= r_exp_len) begin
                desc.has_tail  = 1'b1;
                desc.tail_cp   = bad_val ? REPLACEMENT_CP : cont_val;
                desc.tail_repl = bad_val;
                n_exp_len      = LEN_NONE;
                n_seen         = 2'd0;
                n_part         = '0;
            end else begin
                n_seen = seen_inc[1:0];
                n_part = cont_val;
            end
        end else begin
            // broken sequence flush, then the byte as a new lead
            desc.rep_cnt = pending ? r_seen : 2'd0;
            n_exp_len    = LEN_NONE;
            n_seen       = 2'd0;
            n_part       = '0;
            if (!i_data_byte[7]) begin
                desc.has_tail = 1'b1;
                desc.tail_cp  = {{(CP_W-BYTE_W){1'b0}}, i_data_byte};
            end else if ((i_data_byte & LEAD2_MASK) == LEAD2_CODE) begin
                n_exp_len = LEN_2;
                n_seen    = 2'd1;
                n_part    = {{(CP_W-BYTE_W){1'b0}}, i_data_byte & PAY2_MASK};
            end else if ((i_data_byte & LEAD3_MASK) == LEAD3_CODE) begin
                n_exp_len = LEN_3;
                n_seen    = 2'd1;
                n_part    = {{(CP_W-BYTE_W){1'b0}}, i_data_byte & PAY3_MASK};
            end else if ((i_data_byte & LEAD4_MASK) == LEAD4_CODE) begin
                n_exp_len = LEN_4;
                n_seen    = 2'd1;
                n_part    = {{(CP_W-BYTE_W){1'b0}}, i_data_byte & PAY4_MASK};
            end else begin
                desc.has_tail  = 1'b1;
                desc.tail_cp   = REPLACEMENT_CP;
                desc.tail_repl = 1'b1;
            end
        end
    end

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len <= LEN_NONE;
            r_seen    <= 2'd0;
            r_part    <= '0;
        end else if (accept) begin
            r_exp_len <= n_exp_len;
            r_seen    <= n_seen;
            r_part    <= n_part;
        end
    end

    // only items that cause results go to the queue
    assign o_push = accept && ((desc.rep_cnt != 2'd0) || desc.has_tail);
    assign o_desc = desc;

endmodule

// ===== rtl/utf8d_queue.sv =====
// small descriptor queue between front end and back end
`timescale 1ns / 1ps

module utf8d_queue #(
    parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  utf8d_pkg::t_desc      i_desc,
    input  logic                  i_pop,
    output utf8d_pkg::t_desc      o_head,
    output utf8d_pkg::t_q_status  o_status
);
    import utf8d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_desc            r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign do_push = i_push && (r_count != CNT_FULL);

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_desc;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head          = r_slot[r_rd_ptr];
    assign o_status.valid  = r_count != '0;
    assign o_status.full   = r_count == CNT_FULL;

endmodule

// ===== rtl/utf8d_back.sv =====
// back end: expands descriptors into result transfers through an output register
`timescale 1ns / 1ps

module utf8d_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  utf8d_pkg::t_desc                    i_head,
    input  utf8d_pkg::t_q_status                i_q_status,
    output logic                                o_pop,
    output logic                                o_m_valid,
    input  logic                                i_m_ready,
    output logic [utf8d_pkg::CP_W-1:0]          o_code_point,
    output logic                                o_was_replaced,
    output logic                                o_end_marker,
    output logic                                o_last_of_run
);
    import utf8d_pkg::*;

    logic [1:0]      r_idx;
    logic            r_valid;
    logic [CP_W-1:0] r_cp;
    logic            r_repl, r_endm, r_last;

    logic            advance;
    logic            cur_is_rep;
    logic            cur_last;
    logic [CP_W-1:0] cur_cp;
    logic            cur_repl, cur_endm;

    // pick the next result of the head descriptor
    assign cur_is_rep = r_idx < i_head.rep_cnt;
    assign cur_last   = cur_is_rep ? ((r_idx == i_head.rep_cnt - 2'd1) && !i_head.has_tail)
                                   : 1'b1;
    assign cur_cp     = cur_is_rep ? REPLACEMENT_CP : i_head.tail_cp;
    assign cur_repl   = cur_is_rep ? 1'b1 : i_head.tail_repl;
    assign cur_endm   = cur_is_rep ? 1'b0 : i_head.tail_end;

    assign advance = i_q_status.valid && (!r_valid || i_m_ready);
    assign o_pop   = advance && cur_last;

    // result index within the descriptor and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_idx   <= cur_last ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_cp   <= cur_cp;
            r_repl <= cur_repl;
            r_endm <= cur_endm;
            r_last <= cur_last;
        end
    end

    assign o_m_valid      = r_valid;
    assign o_code_point   = r_cp;
    assign o_was_replaced = r_repl;
    assign o_end_marker   = r_endm;
    assign o_last_of_run  = r_last;

endmodule

// ===== rtl/utf8_stream_decoder_core.sv =====
// UTF-8 byte stream to Unicode code point decoder, top level
//
// input stream: one UTF-8 byte per transfer in s_axis_tdata; s_axis_tlast
// marks the string terminator (a zero byte counts as a terminator as well).
// output stream: one code point per transfer in m_axis_tdata, flags in
// m_axis_tuser, m_axis_tlast on the final result caused by an input byte.
// invalid input yields U+FFFD with the replaced flag; a terminator flushes a
// pending partial sequence as replacements and then sends one end marker.
// each result passes through the descriptor queue and the output register.
// throughput: one byte per cycle while each byte causes at most one result
// and the receiver is ready; up to four results of one byte go out one by
// one through the single result register of the back end. bytes that only
// extend a sequence cause no transfer. the descriptor queue (QUEUE_DEPTH
// entries) absorbs such bursts; s_axis_tready drops only while it is full.
// reset clears the pending sequence, the queue and the output valid.
// when the receiver stalls, the held result stays put and input is still
// taken until the queue fills.
`timescale 1ns / 1ps

module utf8_stream_decoder_core #(
    parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // data_byte
    input  logic                               s_axis_tlast,  // end_of_string
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [utf8d_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // code_point, zero pad
    output logic [utf8d_pkg::OUT_USER_W-1:0]   m_axis_tuser,  // was_replaced, end_marker
    output logic                               m_axis_tlast   // last_of_run
);
    import utf8d_pkg::*;

    t_desc           push_desc;
    t_desc           head_desc;
    t_q_status       q_status;
    logic            push;
    logic            pop;
    logic [CP_W-1:0] code_point;
    logic            was_replaced;
    logic            end_marker;

    // byte intake and classification
    utf8d_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_valid       (s_axis_tvalid),
        .i_data_byte     (s_axis_tdata),
        .i_end_of_string (s_axis_tlast),
        .i_q_full        (q_status.full),
        .o_s_ready       (s_axis_tready),
        .o_push          (push),
        .o_desc          (push_desc)
    );

    // descriptor queue
    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_desc   (push_desc),
        .i_pop    (pop),
        .o_head   (head_desc),
        .o_status (q_status)
    );

    // result expansion and output register
    utf8d_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_desc),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_m_valid      (m_axis_tvalid),
        .i_m_ready      (m_axis_tready),
        .o_code_point   (code_point),
        .o_was_replaced (was_replaced),
        .o_end_marker   (end_marker),
        .o_last_of_run  (m_axis_tlast)
    );

    // output packing
    assign m_axis_tdata = {{(OUT_DATA_W-CP_W){1'b0}}, code_point};
    assign m_axis_tuser = {end_marker, was_replaced};

endmodule

// ===== rtl/utf8d_checker.sv =====
// port-level checks of the decoder and their binding to the top level
`timescale 1ns / 1ps

module utf8d_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [utf8d_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic [utf8d_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    input  logic                               m_axis_tlast
);
    import utf8d_pkg::*;

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // end marker closes the run and carries code point zero
    a_end_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && (m_axis_tdata == '0)
            && !m_axis_tuser[0])
        else $error("malformed end marker");

    // replacement flag goes with U+FFFD
    a_replaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[CP_W-1:0] == REPLACEMENT_CP)
        else $error("replaced result without U+FFFD");

    // code points stay in the unicode range and outside the surrogates
    a_cp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata <= OUT_DATA_W'(CP_MAX))
            && !((m_axis_tdata >= OUT_DATA_W'(SURR_LO))
            && (m_axis_tdata <= OUT_DATA_W'(SURR_HI))))
        else $error("code point out of range");

endmodule

bind utf8_stream_decoder_core utf8d_checker u_utf8d_checker (.*);
